@@ rtl/core/bcpl_pkg.sv @@
// bcpl_pkg: shared widths, register indexes, reset values, frame layout and
// saturation helper for the balance controller link.
// No dependencies; compiled first.
package bcpl_pkg;

   localparam int ACC_W         = 64;
   localparam int WORD_W        = 32;
   localparam int HALF_W        = 16;
   localparam int BYTE_W        = 8;
   localparam int MUL_B_W       = 18;
   localparam int FRAC_BITS_DEF = 16;
   localparam int DEN_W_DEF     = FRAC_BITS_DEF + 12;
   localparam int SETP_FRAC     = 12;

   localparam int CSR_IDX_W = 3;
   localparam int REG_W     = 16;
   localparam int REG_COUNT = 7;

   localparam logic [CSR_IDX_W-1:0] REG_ANGLE_KP  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ANGLE_KI  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ANGLE_KD  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SETPOINT  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_FWD_SPEED = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_SPEED_KP  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_SPEED_KI  = 3'd6;

   localparam logic [REG_W-1:0] RST_ANGLE_KP  = 16'd12800;
   localparam logic [REG_W-1:0] RST_ANGLE_KI  = 16'd0;
   localparam logic [REG_W-1:0] RST_ANGLE_KD  = 16'd410;
   localparam logic [REG_W-1:0] RST_SETPOINT  = 16'hFE14;
   localparam logic [REG_W-1:0] RST_FWD_SPEED = 16'd0;
   localparam logic [REG_W-1:0] RST_SPEED_KP  = 16'd288;
   localparam logic [REG_W-1:0] RST_SPEED_KI  = 16'd2304;

   localparam logic [BYTE_W-1:0] SYNC_BYTE   = 8'h01;
   localparam logic [BYTE_W-1:0] HEADER_BYTE = 8'hAA;

   localparam logic [3:0] POS_IDLE       = 4'd0;
   localparam logic [3:0] POS_FIRST_DATA = 4'd2;
   localparam logic [3:0] POS_LAST_DATA  = 4'd9;
   localparam logic [3:0] POS_FRAME_END  = 4'd10;

   typedef struct packed {
      logic              go;
      logic [HALF_W-1:0] left_count;
      logic [HALF_W-1:0] right_count;
      logic [HALF_W-1:0] accel_x;
      logic [HALF_W-1:0] gyro_y;
   } frame_type;

   localparam logic signed [ACC_W-1:0] S32_MAX = 64'sh0000_0000_7FFF_FFFF;
   localparam logic signed [ACC_W-1:0] S32_MIN = -64'sh0000_0000_8000_0000;

   function automatic logic signed [WORD_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
      logic signed [WORD_W-1:0] r;
      r = v[WORD_W-1:0];
      if (v > S32_MAX) begin
         r = S32_MAX[WORD_W-1:0];
      end else if (v < S32_MIN) begin
         r = S32_MIN[WORD_W-1:0];
      end
      return r;
   endfunction

endpackage

@@ rtl/core/bcpl_ifs.sv @@
// bcpl_ifs: valid/ready channel interfaces for received bytes and reply bytes.
// Depends on bcpl_pkg for widths.
interface bcpl_req_if;
   logic                          valid;
   logic                          ready;
   logic [bcpl_pkg::BYTE_W-1:0]   rx_byte;
   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface bcpl_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [bcpl_pkg::BYTE_W-1:0]   tx_byte;
   logic                          last_of_frame;
   modport source (output valid, output tx_byte, output last_of_frame, input ready);
   modport sink (input valid, input tx_byte, input last_of_frame, output ready);
endinterface

@@ rtl/core/bcpl_mul.sv @@
// bcpl_mul: bit-serial signed multiplier, one multiplier bit per cycle.
// Depends on bcpl_pkg.
module bcpl_mul (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                go,
   input  logic signed [bcpl_pkg::ACC_W-1:0]   a,
   input  logic signed [bcpl_pkg::MUL_B_W-1:0] b,
   output logic                                done,
   output logic signed [bcpl_pkg::ACC_W-1:0]   res
);
   localparam int AW    = bcpl_pkg::ACC_W;
   localparam int BW    = bcpl_pkg::MUL_B_W;
   localparam int CNT_W = $clog2(BW + 1);

   typedef enum logic [1:0] {MU_IDLE, MU_RUN, MU_FIN} mu_state_type;

   mu_state_type     st_ff;
   logic [AW-1:0]    ma_ff;
   logic [BW-1:0]    mb_ff;
   logic [AW-1:0]    acc_ff;
   logic             neg_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             done_ff;
   logic signed [AW-1:0] res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= MU_IDLE;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         unique case (st_ff)
            MU_IDLE: begin
               if (go) begin
                  ma_ff  <= a[AW-1] ? AW'(-a) : AW'(a);
                  mb_ff  <= b[BW-1] ? BW'(-b) : BW'(b);
                  neg_ff <= a[AW-1] ^ b[BW-1];
                  acc_ff <= '0;
                  cnt_ff <= CNT_W'(BW);
                  st_ff  <= MU_RUN;
               end
            end
            MU_RUN: begin
               // add the shifted multiplicand on a set bit, then advance
               if (mb_ff[0]) begin
                  acc_ff <= acc_ff + ma_ff;
               end
               ma_ff  <= {ma_ff[AW-2:0], 1'b0};
               mb_ff  <= {1'b0, mb_ff[BW-1:1]};
               cnt_ff <= cnt_ff - 1'b1;
               if (cnt_ff == CNT_W'(1)) begin
                  st_ff <= MU_FIN;
               end
            end
            MU_FIN: begin
               res_ff  <= neg_ff ? -signed'(acc_ff) : signed'(acc_ff);
               done_ff <= 1'b1;
               st_ff   <= MU_IDLE;
            end
            default: st_ff <= MU_IDLE;
         endcase
      end
   end

   assign done = done_ff;
   assign res  = res_ff;
endmodule

@@ rtl/core/bcpl_div.sv @@
// bcpl_div: bit-serial restoring divider, one quotient bit per cycle, with
// optional round-to-nearest (ties away from zero). Depends on bcpl_pkg.
module bcpl_div #(
   parameter int DEN_W = bcpl_pkg::DEN_W_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              go,
   input  logic signed [bcpl_pkg::ACC_W-1:0] num,
   input  logic [DEN_W-1:0]                  den,
   input  logic                              rnd,
   output logic                              done,
   output logic signed [bcpl_pkg::ACC_W-1:0] res
);
   localparam int AW    = bcpl_pkg::ACC_W;
   localparam int CNT_W = $clog2(AW + 1);

   typedef enum logic [1:0] {DV_IDLE, DV_PREP, DV_RUN, DV_FIN} dv_state_type;

   dv_state_type     st_ff;
   logic [AW-1:0]    dq_ff;
   logic [DEN_W-1:0] rem_ff;
   logic [DEN_W-1:0] den_ff;
   logic             rnd_ff;
   logic             neg_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             done_ff;
   logic signed [AW-1:0] res_ff;

   logic [DEN_W:0]   shifted;
   logic [DEN_W+1:0] trial;
   logic             fits;

   assign shifted = {rem_ff, dq_ff[AW-1]};
   assign trial   = {1'b0, shifted} - {2'b00, den_ff};
   assign fits    = ~trial[DEN_W+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= DV_IDLE;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         unique case (st_ff)
            DV_IDLE: begin
               if (go) begin
                  dq_ff  <= num[AW-1] ? AW'(-num) : AW'(num);
                  neg_ff <= num[AW-1];
                  den_ff <= den;
                  rnd_ff <= rnd;
                  st_ff  <= DV_PREP;
               end
            end
            DV_PREP: begin
               // add half the divisor for rounding
               dq_ff  <= dq_ff + (rnd_ff ? AW'(den_ff >> 1) : '0);
               rem_ff <= '0;
               cnt_ff <= CNT_W'(AW);
               st_ff  <= DV_RUN;
            end
            DV_RUN: begin
               rem_ff <= fits ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
               dq_ff  <= {dq_ff[AW-2:0], fits};
               cnt_ff <= cnt_ff - 1'b1;
               if (cnt_ff == CNT_W'(1)) begin
                  st_ff <= DV_FIN;
               end
            end
            DV_FIN: begin
               res_ff  <= neg_ff ? -signed'(dq_ff) : signed'(dq_ff);
               done_ff <= 1'b1;
               st_ff   <= DV_IDLE;
            end
            default: st_ff <= DV_IDLE;
         endcase
      end
   end

   assign done = done_ff;
   assign res  = res_ff;
endmodule

@@ rtl/core/bcpl_frame.sv @@
// bcpl_frame: sync search and byte shift register for one sensor frame.
// Depends on bcpl_pkg and bcpl_req_if.
module bcpl_frame (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 enable,
   bcpl_req_if.sink             req_ch,
   output bcpl_pkg::frame_type  frame
);
   localparam int SR_W = 8 * bcpl_pkg::BYTE_W;

   logic [3:0]      pos_ff;
   logic [SR_W-1:0] sr_ff;
   logic            go_ff;
   logic            accept;
   logic [3:0]      pos_next;

   assign req_ch.ready = enable & ~go_ff;
   assign accept       = req_ch.valid & req_ch.ready;
   assign pos_next     = pos_ff + 4'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= bcpl_pkg::POS_IDLE;
         go_ff  <= 1'b0;
      end else begin
         go_ff <= 1'b0;
         if (accept) begin
            if (pos_ff != bcpl_pkg::POS_IDLE) begin
               if (pos_next >= bcpl_pkg::POS_FIRST_DATA &&
                   pos_next <= bcpl_pkg::POS_LAST_DATA) begin
                  sr_ff <= {sr_ff[SR_W-bcpl_pkg::BYTE_W-1:0], req_ch.rx_byte};
               end
               if (pos_next == bcpl_pkg::POS_FRAME_END) begin
                  pos_ff <= bcpl_pkg::POS_IDLE;
                  go_ff  <= 1'b1;
               end else begin
                  pos_ff <= pos_next;
               end
            end else if (req_ch.rx_byte == bcpl_pkg::SYNC_BYTE) begin
               pos_ff <= 4'd1;
            end
         end
      end
   end

   assign frame.go          = go_ff;
   assign frame.left_count  = sr_ff[63:48];
   assign frame.right_count = sr_ff[47:32];
   assign frame.accel_x     = sr_ff[31:16];
   assign frame.gyro_y      = sr_ff[15:0];
endmodule

@@ rtl/core/balance_cascade_pid_link.sv @@
// balance_cascade_pid_link: top level of the balance controller link.
// Depends on bcpl_pkg, bcpl_ifs, bcpl_frame, bcpl_mul and bcpl_div.
//
// Usage:
//  - req_ch carries received bytes. A 0x01 byte while idle opens a frame; the
//    next eight bytes are data and a ninth closes it (a 0x01 inside a frame is plain data).
//  - On the ninth byte after the sync the controller runs: complementary tilt
//    filter, angle PID with windup reset, then a PI loop per wheel. rsp_ch then gives
//    three items: 0xAA, left PWM, right PWM (last_of_frame set on the third).
//  - The arithmetic runs on one bit-serial multiplier and one bit-serial
//    divider, driven by a sequencer; one frame needs up to 21 products and
//    15 quotients before the header appears.
//  - req_ch.ready stays low from the last frame byte until the third reply
//    item is taken; at other times bytes outside a frame are taken and dropped.
//  - If the receiver stalls, the current reply item holds on rsp_ch.
//  - Reset (synchronous, active high) clears the filter, integrators, wheel
//    history and frame search, and loads the register defaults.
//  - csr_* writes one gain/setpoint register per cycle; index 7 is ignored.
module balance_cascade_pid_link #(
   parameter int FRAC_BITS = bcpl_pkg::FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   bcpl_req_if.sink                          req_ch,
   bcpl_rsp_if.source                        rsp_ch,
   input  logic                              csr_we,
   input  logic [bcpl_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [bcpl_pkg::REG_W-1:0]        csr_wdata
);
   localparam int AW    = bcpl_pkg::ACC_W;
   localparam int WW    = bcpl_pkg::WORD_W;
   localparam int HW    = bcpl_pkg::HALF_W;
   localparam int BW    = bcpl_pkg::BYTE_W;
   localparam int MBW   = bcpl_pkg::MUL_B_W;
   localparam int DEN_W = FRAC_BITS + 12;

   localparam logic signed [AW-1:0] ONE         = 64'sd1 << FRAC_BITS;
   localparam logic signed [AW-1:0] ULIM        = 5 * ONE;
   localparam logic signed [AW-1:0] NEG_ULIM    = -ULIM;
   localparam logic signed [AW-1:0] ULIM_RELOAD = (9 * ONE) / 2;
   localparam logic signed [AW-1:0] VLIM        = (21 * ONE) / 2;
   localparam logic signed [AW-1:0] NEG_VLIM    = -VLIM;
   localparam logic signed [AW-1:0] VLIM_RELOAD = (9975 * ONE + 500) / 1000;
   localparam logic [DEN_W-1:0]     PWM_DEN     = DEN_W'(1120 * ONE);

   localparam logic [DEN_W-1:0] DEN_ACCEL = DEN_W'(16384);
   localparam logic [DEN_W-1:0] DEN_GYRO  = DEN_W'(131);
   localparam logic [DEN_W-1:0] DEN_TILT  = DEN_W'(100000);
   localparam logic [DEN_W-1:0] DEN_PHI   = DEN_W'(1800000);
   localparam logic [DEN_W-1:0] DEN_INTEG = DEN_W'(256000);
   localparam logic [DEN_W-1:0] DEN_DERIV = DEN_W'(8960);
   localparam logic [DEN_W-1:0] DEN_GAIN  = DEN_W'(256);
   localparam logic [DEN_W-1:0] DEN_SPEED = DEN_W'(571200);

   localparam logic signed [MBW-1:0] K_ACCEL   = 18'sd90;
   localparam logic signed [MBW-1:0] K_MILLI   = 18'sd1000;
   localparam logic signed [MBW-1:0] K_PERIOD  = 18'sd35;
   localparam logic signed [MBW-1:0] K_HIGH    = 18'sd98;
   localparam logic signed [MBW-1:0] K_LOW     = 18'sd2000;
   localparam logic signed [MBW-1:0] K_DEG2RAD = -18'sd31416;
   localparam logic signed [MBW-1:0] K_SPEED   = 18'sd62832;
   localparam logic signed [MBW-1:0] K_PWM     = 18'sd12700;
   localparam logic signed [16:0]    DC_LIMIT  = 17'sd2597;

   typedef enum logic [5:0] {
      ST_IDLE, ST_WAIT, ST_AX_M, ST_AX_D, ST_GY_D, ST_TL_M1, ST_TL_M2, ST_TL_M3,
      ST_TL_M4, ST_TL_D, ST_PH_M, ST_PH_D, ST_ERR, ST_AI_M1, ST_AI_M2, ST_AI_D,
      ST_AI_ADD, ST_AD_M1, ST_AD_M2, ST_AD_D, ST_AP_M, ST_AP_D, ST_AU1, ST_AU2,
      ST_AU3, ST_WH, ST_WS_M, ST_WS_D, ST_WS_SET, ST_WE, ST_WI_M1, ST_WI_M2,
      ST_WI_D, ST_WI_ADD, ST_WP_M, ST_WP_D, ST_WDRV, ST_WPW_M, ST_WPW_D, ST_WPWM,
      ST_OUT
   } seq_state_type;

   // configuration registers
   logic [bcpl_pkg::REG_W-1:0] cfg_ff [bcpl_pkg::REG_COUNT];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff[bcpl_pkg::REG_ANGLE_KP]  <= bcpl_pkg::RST_ANGLE_KP;
         cfg_ff[bcpl_pkg::REG_ANGLE_KI]  <= bcpl_pkg::RST_ANGLE_KI;
         cfg_ff[bcpl_pkg::REG_ANGLE_KD]  <= bcpl_pkg::RST_ANGLE_KD;
         cfg_ff[bcpl_pkg::REG_SETPOINT]  <= bcpl_pkg::RST_SETPOINT;
         cfg_ff[bcpl_pkg::REG_FWD_SPEED] <= bcpl_pkg::RST_FWD_SPEED;
         cfg_ff[bcpl_pkg::REG_SPEED_KP]  <= bcpl_pkg::RST_SPEED_KP;
         cfg_ff[bcpl_pkg::REG_SPEED_KI]  <= bcpl_pkg::RST_SPEED_KI;
      end else if (csr_we && (csr_index < bcpl_pkg::CSR_IDX_W'(bcpl_pkg::REG_COUNT))) begin
         cfg_ff[csr_index] <= csr_wdata;
      end
   end

   function automatic logic signed [MBW-1:0] gain_ext(input logic [bcpl_pkg::REG_W-1:0] g);
      return MBW'(signed'(g));
   endfunction

   // sequencer state
   seq_state_type state_ff, ret_ff;
   logic                 mul_go_ff, div_go_ff, div_rnd_ff;
   logic signed [AW-1:0] mul_a_ff, div_num_ff;
   logic signed [MBW-1:0] mul_b_ff;
   logic [DEN_W-1:0]     div_den_ff;

   // controller state
   logic signed [WW-1:0] tilt_ff, prev_err_ff, ang_int_ff;
   logic [HW-1:0]        prev_cnt_ff [2];
   logic signed [WW-1:0] held_ff [2];
   logic signed [WW-1:0] spd_int_ff [2];

   // per-frame work registers
   logic [HW-1:0]        cnt_ff [2];
   logic [HW-1:0]        accel_ff, gyro_ff;
   logic signed [AW-1:0] ax_ff, gy_ff, t_ff, u_ff;
   logic signed [WW-1:0] err_ff;
   logic signed [16:0]   dc_ff;
   logic                 w_ff;
   logic [BW-1:0]        pwm_l_ff, pwm_r_ff;

   // reply register
   logic          rsp_valid_ff, rsp_last_ff;
   logic [BW-1:0] rsp_byte_ff;
   logic [1:0]    show_ff;

   bcpl_pkg::frame_type  frame;
   logic                 mul_done, div_done;
   logic signed [AW-1:0] mul_res, div_res;

   bcpl_frame u_frame (
      .clock  (clock),
      .reset  (reset),
      .enable (state_ff == ST_IDLE),
      .req_ch (req_ch),
      .frame  (frame)
   );

   bcpl_mul u_mul (
      .clock (clock),
      .reset (reset),
      .go    (mul_go_ff),
      .a     (mul_a_ff),
      .b     (mul_b_ff),
      .done  (mul_done),
      .res   (mul_res)
   );

   bcpl_div #(.DEN_W(DEN_W)) u_div (
      .clock (clock),
      .reset (reset),
      .go    (div_go_ff),
      .num   (div_num_ff),
      .den   (div_den_ff),
      .rnd   (div_rnd_ff),
      .done  (div_done),
      .res   (div_res)
   );

   // datapath helpers
   logic signed [AW-1:0] sp_ext, fwd_ext, drive_sum, t_mag;
   logic [HW-1:0]        cnt_sel, prev_sel;
   logic signed [WW-1:0] held_sel, spd_sel;
   logic signed [16:0]   dc_calc;
   logic                 dc_ok, ang_in_range, spd_in_range;
   logic [BW-1:0]        pwm_byte;

   assign sp_ext  = AW'(signed'(cfg_ff[bcpl_pkg::REG_SETPOINT]))
                    <<< (FRAC_BITS - bcpl_pkg::SETP_FRAC);
   assign fwd_ext = AW'(signed'(cfg_ff[bcpl_pkg::REG_FWD_SPEED]))
                    <<< (FRAC_BITS - bcpl_pkg::SETP_FRAC);
   assign cnt_sel  = cnt_ff[w_ff];
   assign prev_sel = prev_cnt_ff[w_ff];
   assign held_sel = held_ff[w_ff];
   assign spd_sel  = spd_int_ff[w_ff];
   assign dc_calc  = signed'({1'b0, cnt_sel}) - signed'({1'b0, prev_sel});
   assign dc_ok    = (dc_calc <= DC_LIMIT) && (dc_calc >= -DC_LIMIT);
   assign ang_in_range = (AW'(ang_int_ff) < ULIM) && (AW'(ang_int_ff) > NEG_ULIM);
   assign spd_in_range = (AW'(spd_sel) < VLIM) && (AW'(spd_sel) > NEG_VLIM);
   assign drive_sum = div_res + AW'(spd_sel);
   assign t_mag     = t_ff[AW-1] ? -t_ff : t_ff;
   assign pwm_byte  = div_res[BW-1:0] + (t_ff[AW-1] ? 8'h80 : 8'h00);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ret_ff       <= ST_IDLE;
         mul_go_ff    <= 1'b0;
         div_go_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         show_ff      <= 2'd0;
         w_ff         <= 1'b0;
         tilt_ff      <= '0;
         prev_err_ff  <= '0;
         ang_int_ff   <= '0;
         prev_cnt_ff[0] <= '0;
         prev_cnt_ff[1] <= '0;
         held_ff[0]     <= '0;
         held_ff[1]     <= '0;
         spd_int_ff[0]  <= '0;
         spd_int_ff[1]  <= '0;
      end else begin
         // unit starts are single-cycle pulses
         mul_go_ff <= 1'b0;
         div_go_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (frame.go) begin
                  cnt_ff[0] <= frame.left_count;
                  cnt_ff[1] <= frame.right_count;
                  accel_ff  <= frame.accel_x;
                  gyro_ff   <= frame.gyro_y;
                  state_ff  <= ST_AX_M;
               end
            end
            ST_WAIT: begin
               if (mul_done || div_done) begin
                  state_ff <= ret_ff;
               end
            end
            // complementary filter
            ST_AX_M: begin
               mul_a_ff <= AW'(signed'(accel_ff)); mul_b_ff <= K_ACCEL;
               mul_go_ff <= 1'b1; ret_ff <= ST_AX_D; state_ff <= ST_WAIT;
            end
            ST_AX_D: begin
               div_num_ff <= mul_res <<< FRAC_BITS; div_den_ff <= DEN_ACCEL;
               div_rnd_ff <= 1'b1; div_go_ff <= 1'b1;
               ret_ff <= ST_GY_D; state_ff <= ST_WAIT;
            end
            ST_GY_D: begin
               ax_ff <= div_res;
               div_num_ff <= AW'(signed'(gyro_ff)) <<< FRAC_BITS; div_den_ff <= DEN_GYRO;
               div_rnd_ff <= 1'b1; div_go_ff <= 1'b1;
               ret_ff <= ST_TL_M1; state_ff <= ST_WAIT;
            end
            ST_TL_M1: begin
               gy_ff <= div_res;
               mul_a_ff <= AW'(tilt_ff); mul_b_ff <= K_MILLI;
               mul_go_ff <= 1'b1; ret_ff <= ST_TL_M2; state_ff <= ST_WAIT;
            end
            ST_TL_M2: begin
               t_ff <= mul_res;
               mul_a_ff <= gy_ff; mul_b_ff <= K_PERIOD;
               mul_go_ff <= 1'b1; ret_ff <= ST_TL_M3; state_ff <= ST_WAIT;
            end
            ST_TL_M3: begin
               mul_a_ff <= t_ff - mul_res; mul_b_ff <= K_HIGH;
               mul_go_ff <= 1'b1; ret_ff <= ST_TL_M4; state_ff <= ST_WAIT;
            end
            ST_TL_M4: begin
               t_ff <= mul_res;
               mul_a_ff <= ax_ff; mul_b_ff <= K_LOW;
               mul_go_ff <= 1'b1; ret_ff <= ST_TL_D; state_ff <= ST_WAIT;
            end
            ST_TL_D: begin
               div_num_ff <= t_ff + mul_res; div_den_ff <= DEN_TILT;
               div_rnd_ff <= 1'b1; div_go_ff <= 1'b1;
               ret_ff <= ST_PH_M; state_ff <= ST_WAIT;
            end
            ST_PH_M: begin
               tilt_ff <= bcpl_pkg::sat32(div_res);
               mul_a_ff <= AW'(bcpl_pkg::sat32(div_res)); mul_b_ff <= K_DEG2RAD;
               mul_go_ff <= 1'b1; ret_ff <= ST_PH_D; state_ff <= ST_WAIT;
            end
            ST_PH_D: begin
               div_num_ff <= mul_res; div_den_ff <= DEN_PHI;
               div_rnd_ff <= 1'b1; div_go_ff <= 1'b1;
               ret_ff <= ST_ERR; state_ff <= ST_WAIT;
            end
            // angle PID
            ST_ERR: begin
               err_ff <= bcpl_pkg::sat32(sp_ext - div_res);
               if (ang_in_range) begin
                  state_ff <= ST_AI_M1;
               end else begin
                  // windup: reload and skip accumulation this frame
                  ang_int_ff <= (AW'(ang_int_ff) >= ULIM) ? ULIM_RELOAD[WW-1:0]
                                                          : WW'(-ULIM_RELOAD);
                  state_ff <= ST_AD_M1;
               end
            end
            ST_AI_M1: begin
               mul_a_ff <= AW'(err_ff); mul_b_ff <= gain_ext(cfg_ff[bcpl_pkg::REG_ANGLE_KI]);
               mul_go_ff <= 1'b1; ret_ff <= ST_AI_M2; state_ff <= ST_WAIT;
            end
            ST_AI_M2: begin
               mul_a_ff <= mul_res; mul_b_ff <= K_PERIOD;
               mul_go_ff <= 1'b1; ret_ff <= ST_AI_D; state_ff <= ST_WAIT;
            end
            ST_AI_D: begin
               div_num_ff <= mul_res; div_den_ff <= DEN_INTEG;
               div_rnd_ff <= 1'b1; div_go_ff <= 1'b1;
               ret_ff <= ST_AI_ADD; state_ff <= ST_WAIT;
            end
            ST_AI_ADD: begin
               ang_int_ff <= bcpl_pkg::sat32(AW'(ang_int_ff) + div_res);
               state_ff   <= ST_AD_M1;
            end
            ST_AD_M1: begin
               mul_a_ff <= AW'(err_ff) - AW'(prev_err_ff);
               mul_b_ff <= gain_ext(cfg_ff[bcpl_pkg::REG_ANGLE_KD]);
               mul_go_ff <= 1'b1; ret_ff <= ST_AD_M2; state_ff <= ST_WAIT;
            end
            ST_AD_M2: begin
               mul_a_ff <= mul_res; mul_b_ff <= K_MILLI;
               mul_go_ff <= 1'b1; ret_ff <= ST_AD_D; state_ff <= ST_WAIT;
            end
            ST_AD_D: begin
               div_num_ff <= mul_res; div_den_ff <= DEN_DERIV;
               div_rnd_ff <= 1'b1; div_go_ff <= 1'b1;
               ret_ff <= ST_AP_M; state_ff <= ST_WAIT;
            end
            ST_AP_M: begin
               u_ff <= div_res;
               mul_a_ff <= AW'(err_ff); mul_b_ff <= gain_ext(cfg_ff[bcpl_pkg::REG_ANGLE_KP]);
               mul_go_ff <= 1'b1; ret_ff <= ST_AP_D; state_ff <= ST_WAIT;
            end
            ST_AP_D: begin
               div_num_ff <= mul_res; div_den_ff <= DEN_GAIN;
               div_rnd_ff <= 1'b1; div_go_ff <= 1'b1;
               ret_ff <= ST_AU1; state_ff <= ST_WAIT;
            end
            ST_AU1: begin
               u_ff <= u_ff + div_res;
               state_ff <= ST_AU2;
            end
            ST_AU2: begin
               u_ff <= u_ff + AW'(ang_int_ff) + fwd_ext;
               state_ff <= ST_AU3;
            end
            ST_AU3: begin
               // clamp the wheel speed demand
               if (u_ff > ULIM) begin
                  u_ff <= ULIM;
               end else if (u_ff < NEG_ULIM) begin
                  u_ff <= NEG_ULIM;
               end
               prev_err_ff <= err_ff;
               w_ff        <= 1'b0;
               state_ff    <= ST_WH;
            end
            // wheel speed loops, left then right
            ST_WH: begin
               prev_cnt_ff[w_ff] <= cnt_sel;
               dc_ff <= dc_calc;
               // hold the last speed on an implausible count jump
               state_ff <= dc_ok ? ST_WS_M : ST_WE;
            end
            ST_WS_M: begin
               mul_a_ff <= AW'(dc_ff); mul_b_ff <= K_SPEED;
               mul_go_ff <= 1'b1; ret_ff <= ST_WS_D; state_ff <= ST_WAIT;
            end
            ST_WS_D: begin
               div_num_ff <= mul_res <<< FRAC_BITS; div_den_ff <= DEN_SPEED;
               div_rnd_ff <= 1'b1; div_go_ff <= 1'b1;
               ret_ff <= ST_WS_SET; state_ff <= ST_WAIT;
            end
            ST_WS_SET: begin
               held_ff[w_ff] <= bcpl_pkg::sat32(div_res);
               state_ff      <= ST_WE;
            end
            ST_WE: begin
               err_ff <= bcpl_pkg::sat32(u_ff - AW'(held_sel));
               if (spd_in_range) begin
                  state_ff <= ST_WI_M1;
               end else begin
                  spd_int_ff[w_ff] <= (AW'(spd_sel) >= VLIM) ? VLIM_RELOAD[WW-1:0]
                                                             : WW'(-VLIM_RELOAD);
                  state_ff <= ST_WP_M;
               end
            end
            ST_WI_M1: begin
               mul_a_ff <= AW'(err_ff); mul_b_ff <= gain_ext(cfg_ff[bcpl_pkg::REG_SPEED_KI]);
               mul_go_ff <= 1'b1; ret_ff <= ST_WI_M2; state_ff <= ST_WAIT;
            end
            ST_WI_M2: begin
               mul_a_ff <= mul_res; mul_b_ff <= K_PERIOD;
               mul_go_ff <= 1'b1; ret_ff <= ST_WI_D; state_ff <= ST_WAIT;
            end
            ST_WI_D: begin
               div_num_ff <= mul_res; div_den_ff <= DEN_INTEG;
               div_rnd_ff <= 1'b1; div_go_ff <= 1'b1;
               ret_ff <= ST_WI_ADD; state_ff <= ST_WAIT;
            end
            ST_WI_ADD: begin
               spd_int_ff[w_ff] <= bcpl_pkg::sat32(AW'(spd_sel) + div_res);
               state_ff <= ST_WP_M;
            end
            ST_WP_M: begin
               mul_a_ff <= AW'(err_ff); mul_b_ff <= gain_ext(cfg_ff[bcpl_pkg::REG_SPEED_KP]);
               mul_go_ff <= 1'b1; ret_ff <= ST_WP_D; state_ff <= ST_WAIT;
            end
            ST_WP_D: begin
               div_num_ff <= mul_res; div_den_ff <= DEN_GAIN;
               div_rnd_ff <= 1'b1; div_go_ff <= 1'b1;
               ret_ff <= ST_WDRV; state_ff <= ST_WAIT;
            end
            ST_WDRV: begin
               // clamp the drive voltage
               if (drive_sum >= VLIM) begin
                  t_ff <= VLIM;
               end else if (drive_sum <= NEG_VLIM) begin
                  t_ff <= NEG_VLIM;
               end else begin
                  t_ff <= drive_sum;
               end
               state_ff <= ST_WPW_M;
            end
            ST_WPW_M: begin
               mul_a_ff <= t_mag; mul_b_ff <= K_PWM;
               mul_go_ff <= 1'b1; ret_ff <= ST_WPW_D; state_ff <= ST_WAIT;
            end
            ST_WPW_D: begin
               div_num_ff <= mul_res; div_den_ff <= PWM_DEN;
               div_rnd_ff <= 1'b0; div_go_ff <= 1'b1;
               ret_ff <= ST_WPWM; state_ff <= ST_WAIT;
            end
            ST_WPWM: begin
               if (!w_ff) begin
                  pwm_l_ff <= pwm_byte;
                  w_ff     <= 1'b1;
                  state_ff <= ST_WH;
               end else begin
                  pwm_r_ff     <= pwm_byte;
                  rsp_valid_ff <= 1'b1;
                  rsp_byte_ff  <= bcpl_pkg::HEADER_BYTE;
                  rsp_last_ff  <= 1'b0;
                  show_ff      <= 2'd0;
                  state_ff     <= ST_OUT;
               end
            end
            // reply: header, left, right; hold while the receiver stalls
            ST_OUT: begin
               if (rsp_ch.ready) begin
                  unique case (show_ff)
                     2'd0: begin
                        rsp_byte_ff <= pwm_l_ff;
                        show_ff     <= 2'd1;
                     end
                     2'd1: begin
                        rsp_byte_ff <= pwm_r_ff;
                        rsp_last_ff <= 1'b1;
                        show_ff     <= 2'd2;
                     end
                     default: begin
                        rsp_valid_ff <= 1'b0;
                        rsp_last_ff  <= 1'b0;
                        show_ff      <= 2'd0;
                        state_ff     <= ST_IDLE;
                     end
                  endcase
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.tx_byte       = rsp_byte_ff;
   assign rsp_ch.last_of_frame = rsp_last_ff;
endmodule

@@ dv/tb_balance_cascade_pid_link.sv @@
`timescale 1ns / 100ps
// tb_balance_cascade_pid_link: self-checking bench for the balance controller link.
// Uses bcpl_pkg, bcpl_ifs and the balance_cascade_pid_link top; predicts each reply in place.

class balance_reply_tracker;
   typedef struct {
      logic [7:0] tx_byte;
      logic       last_of_frame;
   } reply_type;

   localparam longint ONE = 64'sd1 << bcpl_pkg::FRAC_BITS_DEF;

   logic signed [15:0] gain_reg [bcpl_pkg::REG_COUNT];
   int unsigned        position;
   logic [7:0]         captured [8];
   longint             tilt, prev_err, angle_acc;
   longint             prev_count [2];
   longint             wheel_speed [2];
   longint             speed_acc [2];
   reply_type          pending_reply [$];
   int                 errors;
   int                 frames_done;

   function new();
      gain_reg[bcpl_pkg::REG_ANGLE_KP]  = bcpl_pkg::RST_ANGLE_KP;
      gain_reg[bcpl_pkg::REG_ANGLE_KI]  = bcpl_pkg::RST_ANGLE_KI;
      gain_reg[bcpl_pkg::REG_ANGLE_KD]  = bcpl_pkg::RST_ANGLE_KD;
      gain_reg[bcpl_pkg::REG_SETPOINT]  = bcpl_pkg::RST_SETPOINT;
      gain_reg[bcpl_pkg::REG_FWD_SPEED] = bcpl_pkg::RST_FWD_SPEED;
      gain_reg[bcpl_pkg::REG_SPEED_KP]  = bcpl_pkg::RST_SPEED_KP;
      gain_reg[bcpl_pkg::REG_SPEED_KI]  = bcpl_pkg::RST_SPEED_KI;
      position = 0;
      foreach (captured[i]) captured[i] = '0;
      tilt = 0; prev_err = 0; angle_acc = 0;
      for (int w = 0; w < 2; w++) begin
         prev_count[w] = 0; wheel_speed[w] = 0; speed_acc[w] = 0;
      end
      errors = 0;
      frames_done = 0;
   endfunction

   function void write_reg(logic [2:0] idx, logic [15:0] value);
      if (idx < bcpl_pkg::REG_COUNT) gain_reg[idx] = value;
   endfunction

   // round half away from zero; den is always positive
   function longint round_div(longint num, longint den);
      if (num < 0) return -((-num + den / 2) / den);
      return (num + den / 2) / den;
   endfunction

   function longint sat_word(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function longint pair(int i);
      logic signed [15:0] v;
      v = {captured[i], captured[i+1]};
      return longint'(v);
   endfunction

   function longint windup_step(longint acc, longint gain, longint err, longint lim,
                                longint reload);
      if (acc < lim && acc > -lim) return sat_word(acc + round_div(gain * err * 35, 256000));
      return (acc >= lim) ? sat_word(reload) : sat_word(-reload);
   endfunction

   function logic [7:0] wheel_pwm(int w, longint count, longint demand);
      longint vlim, dc, err, drive, mag;
      logic [7:0] pwm;
      vlim = round_div(21 * ONE, 2);
      dc = count - prev_count[w];
      prev_count[w] = count;
      if (dc <= 2597 && dc >= -2597)
         wheel_speed[w] = sat_word(round_div(dc * 62832 * ONE, 571200));
      err = sat_word(demand - wheel_speed[w]);
      speed_acc[w] = windup_step(speed_acc[w], longint'(gain_reg[bcpl_pkg::REG_SPEED_KI]),
                                 err, vlim, round_div(9975 * ONE, 1000));
      drive = round_div(longint'(gain_reg[bcpl_pkg::REG_SPEED_KP]) * err, 256) + speed_acc[w];
      if (drive >= vlim) drive = vlim;
      if (drive <= -vlim) drive = -vlim;
      mag = (drive < 0) ? -drive : drive;
      pwm = 8'((mag * 12700) / (1120 * ONE));
      if (drive < 0) pwm = pwm + 8'd128;
      return pwm;
   endfunction

   // run the whole cascade on a completed frame and queue the three reply items
   function void run_controller();
      longint ax, gy, phi, sp, err, ulim, u;
      logic [7:0] left, right;
      ax = round_div(90 * pair(4) * ONE, 16384);
      gy = round_div(pair(6) * ONE, 131);
      tilt = sat_word(round_div(98 * (tilt * 1000 - gy * 35) + 2000 * ax, 100000));
      phi = round_div(-tilt * 31416, 1800000);
      sp = longint'(gain_reg[bcpl_pkg::REG_SETPOINT]) * 16;
      err = sat_word(sp - phi);
      ulim = 5 * ONE;
      angle_acc = windup_step(angle_acc, longint'(gain_reg[bcpl_pkg::REG_ANGLE_KI]), err, ulim,
                              round_div(9 * ONE, 2));
      u = round_div(longint'(gain_reg[bcpl_pkg::REG_ANGLE_KP]) * err, 256)
        + round_div(longint'(gain_reg[bcpl_pkg::REG_ANGLE_KD]) * (err - prev_err) * 1000, 8960)
        + angle_acc
        + longint'(gain_reg[bcpl_pkg::REG_FWD_SPEED]) * 16;
      prev_err = err;
      if (u > ulim) u = ulim;
      if (u < -ulim) u = -ulim;
      left  = wheel_pwm(0, longint'({captured[0], captured[1]}), u);
      right = wheel_pwm(1, longint'({captured[2], captured[3]}), u);
      pending_reply.push_back('{bcpl_pkg::HEADER_BYTE, 1'b0});
      pending_reply.push_back('{left, 1'b0});
      pending_reply.push_back('{right, 1'b1});
   endfunction

   function void take_rx_byte(logic [7:0] b);
      if (position != 0) begin
         position++;
         if (position >= 2 && position <= 9) captured[position-2] = b;
      end else if (b == bcpl_pkg::SYNC_BYTE) begin
         position = 1;
      end
      if (position >= 10) begin
         position = 0;
         run_controller();
      end
   endfunction

   function void match_tx_byte(logic [7:0] tx, logic last);
      reply_type exp_item;
      if (pending_reply.size() == 0) begin
         $display("%0t: unexpected reply item tx_byte=%02h last_of_frame=%0b", $time, tx, last);
         errors++;
         return;
      end
      exp_item = pending_reply.pop_front();
      if (tx !== exp_item.tx_byte) begin
         $display("%0t: tx_byte mismatch: expected %02h, got %02h",
                  $time, exp_item.tx_byte, tx);
         errors++;
      end
      if (last !== exp_item.last_of_frame) begin
         $display("%0t: last_of_frame mismatch: expected %0b, got %0b",
                  $time, exp_item.last_of_frame, last);
         errors++;
      end
      if (exp_item.last_of_frame) frames_done++;
   endfunction
endclass

module tb_balance_cascade_pid_link;
   localparam int IDX_W = bcpl_pkg::CSR_IDX_W;

   // no acceptance on either side for this many cycles means the block hung
   localparam int HANG_LIMIT = 20000;

   logic clock;
   logic reset;
   logic csr_we;
   logic [IDX_W-1:0] csr_index;
   logic [bcpl_pkg::REG_W-1:0] csr_wdata;

   bcpl_req_if req_if ();
   bcpl_rsp_if rsp_if ();

   balance_cascade_pid_link dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_if),
      .rsp_ch    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   balance_reply_tracker tracker;

   bit quiet;              // when set, neither side inserts gaps
   int idle_cycles;
   int bytes_sent;
   logic [15:0] last_left, last_right;

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // gap length: mostly none or short, now and then long
   function automatic int pick_gap();
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // reply side: hold ready low for random stretches
   int stall_left;
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_if.ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_if.ready <= 1'b1;
         stall_left <= pick_gap();
      end
   end

   // check every accepted reply item against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready)
         tracker.match_tx_byte(rsp_if.tx_byte, rsp_if.last_of_frame);
   end

   // watchdog: count cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= HANG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, HANG_LIMIT);
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   // drive one byte, hold it until taken; valid stays high into the next call
   task automatic send_byte(logic [7:0] b);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.rx_byte <= b;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      tracker.take_rx_byte(b);
      bytes_sent++;
   endtask

   task automatic send_frame(logic [15:0] left, logic [15:0] right, logic [15:0] ax,
                             logic [15:0] gy, logic [7:0] sensor);
      send_byte(bcpl_pkg::SYNC_BYTE);
      send_byte(left[15:8]);  send_byte(left[7:0]);
      send_byte(right[15:8]); send_byte(right[7:0]);
      send_byte(ax[15:8]);    send_byte(ax[7:0]);
      send_byte(gy[15:8]);    send_byte(gy[7:0]);
      send_byte(sensor);
      last_left = left;
      last_right = right;
   endtask

   // bytes while idle that are not a sync; the block drops them
   task automatic send_noise(int n);
      logic [7:0] b;
      repeat (n) begin
         b = 8'($urandom_range(0, 255));
         if (b == bcpl_pkg::SYNC_BYTE) b = 8'h00;
         send_byte(b);
      end
   endtask

   // next count: mostly a plausible step, sometimes a jump around the hold limit, else random
   function automatic logic [15:0] next_count(logic [15:0] prev);
      int r;
      r = $urandom_range(0, 99);
      if (r < 75) return prev + 16'($signed($urandom_range(0, 800)) - 400);
      if (r < 85) return prev + 16'($signed($urandom_range(2590, 2610)) *
                                    ($urandom_range(0, 1) ? 1 : -1));
      return 16'($urandom);
   endfunction

   function automatic logic [15:0] sensor_word();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 16'h7FFF;
      if (r == 1) return 16'h8000;
      if (r < 6) return 16'($signed($urandom_range(0, 4000)) - 2000);
      return 16'($urandom);
   endfunction

   // one write per call, with csr_we dropped between writes
   task automatic write_csr(logic [IDX_W-1:0] idx, logic [bcpl_pkg::REG_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      tracker.write_reg(idx, value);
   endtask

   // hold the sender until every reply is back, then let the block settle
   task automatic drain();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (tracker.pending_reply.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   function automatic logic [15:0] reg_value(int style);
      case (style)
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'h0000;
         3: return 16'($signed($urandom_range(0, 1024)) - 512);
         default: return 16'($urandom);
      endcase
   endfunction

   initial begin
      tracker = new();
      quiet = 1'b0;
      bytes_sent = 0;
      last_left = '0;
      last_right = '0;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_if.valid = 1'b0;
      req_if.rx_byte = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes of counts and sensors, 0x01 inside a frame, ignored noise
      send_byte(8'h00);
      send_byte(8'hFF);
      send_frame(16'h0000, 16'h0000, 16'h0000, 16'h0000, 8'h00);
      send_frame(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 8'hFF);
      send_frame(16'h0101, 16'h0101, 16'h0101, 16'h0101, bcpl_pkg::SYNC_BYTE);
      drain();

      // random phases, each under its own register setting
      for (int phase = 0; phase < 7; phase++) begin
         quiet = (phase % 3 == 1);
         for (int i = 0; i < bcpl_pkg::REG_COUNT; i++) begin
            case (phase)
               0: write_csr(IDX_W'(i), reg_value(0));
               1: write_csr(IDX_W'(i), reg_value(1));
               2: write_csr(IDX_W'(i), reg_value(2));
               3: write_csr(IDX_W'(i), reg_value(3));
               default: write_csr(IDX_W'(i), reg_value($urandom_range(0, 4)));
            endcase
         end
         // the spare index must leave everything untouched
         if (phase == 4) write_csr(IDX_W'(bcpl_pkg::REG_COUNT), 16'($urandom));
         // reload realistic gains in phase 5 so the loops settle rather than rail
         if (phase == 5) begin
            write_csr(bcpl_pkg::REG_ANGLE_KP, bcpl_pkg::RST_ANGLE_KP);
            write_csr(bcpl_pkg::REG_ANGLE_KI, 16'd256);
            write_csr(bcpl_pkg::REG_ANGLE_KD, bcpl_pkg::RST_ANGLE_KD);
            write_csr(bcpl_pkg::REG_SETPOINT, bcpl_pkg::RST_SETPOINT);
            write_csr(bcpl_pkg::REG_SPEED_KP, bcpl_pkg::RST_SPEED_KP);
            write_csr(bcpl_pkg::REG_SPEED_KI, bcpl_pkg::RST_SPEED_KI);
         end
         repeat (6) begin
            if ($urandom_range(0, 3) == 0) send_noise($urandom_range(1, 3));
            send_frame(next_count(last_left), next_count(last_right), sensor_word(),
                       sensor_word(), 8'($urandom));
         end
         drain();
      end

      quiet = 1'b0;
      repeat (50) @(posedge clock);
      $display("Sent %0d bytes; %0d frames of replies checked over 8 register settings.",
               bytes_sent, tracker.frames_done);
      if (tracker.errors == 0 && tracker.pending_reply.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end
endmodule

@@ balance_cascade_pid_link.f @@
rtl/core/bcpl_pkg.sv
rtl/core/bcpl_ifs.sv
rtl/core/bcpl_mul.sv
rtl/core/bcpl_div.sv
rtl/core/bcpl_frame.sv
rtl/core/balance_cascade_pid_link.sv
dv/tb_balance_cascade_pid_link.sv
